/* hdl/qpm_pkg.sv */
package qpm_pkg;

  // measured count width, the only sizing knob (8 to 64)
  localparam int COUNT_WIDTH  = 32;
  // fixed field widths of the channels
  localparam int CMD_WIDTH    = 32;
  localparam int MARGIN_WIDTH = 16;
  localparam int STEP_WIDTH   = 3;
  // error datapath width: holds command minus count without overflow
  localparam int DIFF_WIDTH   = ((COUNT_WIDTH > CMD_WIDTH) ? COUNT_WIDTH : CMD_WIDTH) + 2;

  localparam logic [MARGIN_WIDTH-1:0] MARGIN_RESET = MARGIN_WIDTH'(4);
  localparam logic signed [STEP_WIDTH-1:0] STEP_ILLEGAL = STEP_WIDTH'(2);

  // correction direction codes
  typedef enum logic [1:0] {
    CORR_NONE    = 2'd0,
    CORR_FORWARD = 2'd1,
    CORR_REVERSE = 2'd2
  } corr_e;

  typedef struct packed {
    logic                        chan_a;
    logic                        chan_b;
    logic signed [CMD_WIDTH-1:0] commanded_position;
    logic                        clear;
  } in_beat_t;

  typedef struct packed {
    logic signed [CMD_WIDTH-1:0] position;
    logic signed [CMD_WIDTH-1:0] position_error;
    logic                        lagging;
    logic                        leading;
    corr_e                       correction;
    logic                        illegal_step;
  } out_beat_t;

  typedef struct packed {
    logic [MARGIN_WIDTH-1:0] error_margin;
  } cfg_beat_t;

  // decode stage contents handed to the error stage
  typedef struct packed {
    logic signed [COUNT_WIDTH-1:0] count;
    logic signed [CMD_WIDTH-1:0]   cmd;
    logic                          illegal;
  } dec_t;

  // step for previous filtered state (high two bits) and new state (low two bits)
  function automatic logic signed [STEP_WIDTH-1:0] step_lookup(input logic [3:0] idx);
    logic signed [STEP_WIDTH-1:0] step;
    case (idx)
      4'd0:    step = 3'sd0;
      4'd1:    step = -3'sd1;
      4'd2:    step = 3'sd1;
      4'd3:    step = 3'sd2;
      4'd4:    step = 3'sd1;
      4'd5:    step = 3'sd0;
      4'd6:    step = 3'sd2;
      4'd7:    step = -3'sd1;
      4'd8:    step = -3'sd1;
      4'd9:    step = 3'sd2;
      4'd10:   step = 3'sd0;
      4'd11:   step = 3'sd1;
      4'd12:   step = 3'sd2;
      4'd13:   step = 3'sd1;
      4'd14:   step = -3'sd1;
      4'd15:   step = 3'sd0;
      default: step = 3'sd0;
    endcase
    return step;
  endfunction

endpackage

/* hdl/qpm_stream_if.sv */
interface qpm_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* hdl/qpm_decode.sv */
module qpm_decode import qpm_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  qpm_stream_if.sink   in_ch,
  input  logic         take_i,
  output logic         stg_valid_o,
  output dec_t         stg_o
);

  logic [1:0]                    hist_a_q, hist_a_d;
  logic [1:0]                    hist_b_q, hist_b_d;
  logic                          filt_a_q, filt_a_d;
  logic                          filt_b_q, filt_b_d;
  logic [1:0]                    prev_quad_q, prev_quad_d;
  logic signed [COUNT_WIDTH-1:0] count_q, count_d, count_base;
  logic signed [STEP_WIDTH-1:0]  step;
  logic                          stg_valid_q;
  dec_t                          stg_q, stg_d;
  logic                          accept;

  // stage is free when empty or when the error stage takes it this cycle
  assign in_ch.ready = !stg_valid_q || take_i;
  assign accept      = in_ch.valid && in_ch.ready;

  // glitch filter: three equal samples in a row pass through
  always_comb begin
    filt_a_d = filt_a_q;
    filt_b_d = filt_b_q;
    if (hist_a_q[0] == in_ch.payload.chan_a && hist_a_q[1] == in_ch.payload.chan_a) begin
      filt_a_d = in_ch.payload.chan_a;
    end
    if (hist_b_q[0] == in_ch.payload.chan_b && hist_b_q[1] == in_ch.payload.chan_b) begin
      filt_b_d = in_ch.payload.chan_b;
    end
    hist_a_d = {in_ch.payload.chan_a, hist_a_q[1]};
    hist_b_d = {in_ch.payload.chan_b, hist_b_q[1]};
  end

  // quadrature step and count update
  always_comb begin
    prev_quad_d = {filt_a_d, filt_b_d};
    step        = step_lookup({prev_quad_q, prev_quad_d});
    count_base  = in_ch.payload.clear ? '0 : count_q;
    count_d     = count_base + COUNT_WIDTH'(step);
    stg_d.count   = count_d;
    stg_d.cmd     = in_ch.payload.commanded_position;
    stg_d.illegal = (step == STEP_ILLEGAL);
  end

  // encoder state, advances on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_a_q    <= '0;
      hist_b_q    <= '0;
      filt_a_q    <= 1'b0;
      filt_b_q    <= 1'b0;
      prev_quad_q <= '0;
      count_q     <= '0;
    end else if (accept) begin
      hist_a_q    <= hist_a_d;
      hist_b_q    <= hist_b_d;
      filt_a_q    <= filt_a_d;
      filt_b_q    <= filt_b_d;
      prev_quad_q <= prev_quad_d;
      count_q     <= count_d;
    end
  end

  // stage register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      stg_valid_q <= in_ch.valid;
    end
  end

  // stage register payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      stg_q <= stg_d;
    end
  end

  assign stg_valid_o = stg_valid_q;
  assign stg_o       = stg_q;

endmodule

/* hdl/qpm_error.sv */
module qpm_error import qpm_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    stg_valid_i,
  input  dec_t                    stg_i,
  input  logic [MARGIN_WIDTH-1:0] margin_i,
  output logic                    take_o,
  qpm_stream_if.source            out_ch
);

  logic signed [DIFF_WIDTH-1:0]   diff;
  logic [DIFF_WIDTH-CMD_WIDTH:0]  diff_hi;
  logic signed [CMD_WIDTH-1:0]    err;
  logic signed [CMD_WIDTH+1:0]    err_x, mar_x;
  logic                           out_valid_q;
  out_beat_t                      out_q, out_d;

  // output register loads when empty or drained this cycle
  assign take_o = !out_valid_q || out_ch.ready;

  // commanded minus count, saturated to the command width
  always_comb begin
    diff    = DIFF_WIDTH'(stg_i.cmd) - DIFF_WIDTH'(stg_i.count);
    diff_hi = diff[DIFF_WIDTH-1:CMD_WIDTH-1];
    if ((&diff_hi) || !(|diff_hi)) begin
      err = diff[CMD_WIDTH-1:0];
    end else if (diff[DIFF_WIDTH-1]) begin
      err = {1'b1, {(CMD_WIDTH-1){1'b0}}};
    end else begin
      err = {1'b0, {(CMD_WIDTH-1){1'b1}}};
    end
  end

  // margin flags and correction direction
  always_comb begin
    err_x = (CMD_WIDTH+2)'(err);
    mar_x = $signed((CMD_WIDTH+2)'(margin_i));
    out_d.position       = CMD_WIDTH'(stg_i.count);
    out_d.position_error = err;
    out_d.lagging        = (err_x > mar_x);
    out_d.leading        = (err_x < -mar_x);
    out_d.illegal_step   = stg_i.illegal;
    if (err == '0) begin
      out_d.correction = CORR_NONE;
    end else if (err[CMD_WIDTH-1]) begin
      out_d.correction = CORR_REVERSE;
    end else begin
      out_d.correction = CORR_FORWARD;
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take_o) begin
      out_valid_q <= stg_valid_i;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (take_o && stg_valid_i) begin
      out_q <= out_d;
    end
  end

  assign out_ch.valid   = out_valid_q;
  assign out_ch.payload = out_q;

endmodule

/* hdl/filtered_quadrature_position_monitor.sv */
// two stages: a result beat passes the decode stage register, then the result register
// throughput: one sample beat per cycle unless output stalls, set by the decode count add
// output stalls back up through the two stages; the input stays open while a stage drains
// reset (rst_ni low, asynchronous) clears filters, history, count and both valid flags,
// and sets the error margin to 4
module filtered_quadrature_position_monitor import qpm_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  qpm_stream_if.sink   in_ch,
  qpm_stream_if.source out_ch,
  qpm_stream_if.sink   cfg_ch
);

  logic [MARGIN_WIDTH-1:0] margin_q;
  logic                    stg_valid;
  dec_t                    stg;
  logic                    take;

  // margin register, always ready for a write beat
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q <= MARGIN_RESET;
    end else if (cfg_ch.valid) begin
      margin_q <= cfg_ch.payload.error_margin;
    end
  end

  // filter, step decode and count
  qpm_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .take_i      (take),
    .stg_valid_o (stg_valid),
    .stg_o       (stg)
  );

  // error, flags and result register
  qpm_error u_error (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stg_valid_i (stg_valid),
    .stg_i       (stg),
    .margin_i    (margin_q),
    .take_o      (take),
    .out_ch      (out_ch)
  );

`ifndef NO_ASSERTIONS
  // an accepted sample beat always lands in the decode stage
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ch.valid && in_ch.ready |=> stg_valid)
    else $error("accepted beat did not reach decode stage");

  // a decode stage beat taken by the error stage becomes a result
  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg_valid && take |=> out_ch.valid)
    else $error("decode stage beat lost");

  // a blocked decode stage keeps its beat
  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg_valid && !take |=> stg_valid && $stable(stg))
    else $error("blocked decode stage changed");

  // lag means a positive error, so a forward correction
  a_lag_forward: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.payload.lagging |-> out_ch.payload.correction == CORR_FORWARD)
    else $error("lagging without forward correction");
`endif

endmodule

/* verif/filtered_quadrature_position_monitor_tb.sv */
module filtered_quadrature_position_monitor_tb;
  import qpm_pkg::*;

  localparam longint SAT_HI   = 64'sd2147483647;
  localparam longint SAT_LO   = -64'sd2147483648;
  localparam longint FAR_AWAY = 64'sd1 << 40;
  localparam int     JUMP_STEP = 2;

  // position predictor: glitch filter, x4 decode, count and error against margin
  class position_predictor;
    logic                          hist_a [2];
    logic                          hist_b [2];
    logic                          filt_a;
    logic                          filt_b;
    logic [1:0]                    prev_quad;
    logic signed [COUNT_WIDTH-1:0] count;
    logic [MARGIN_WIDTH-1:0]       margin;
    int                            quad_step [16];
    out_beat_t                     predicted_results [$];
    int                            errors;

    function new();
      hist_a    = '{1'b0, 1'b0};
      hist_b    = '{1'b0, 1'b0};
      filt_a    = 1'b0;
      filt_b    = 1'b0;
      prev_quad = 2'b00;
      count     = '0;
      margin    = 16'd4;
      errors    = 0;
      quad_step = '{0, -1, 1, 2, 1, 0, 2, -1, -1, 2, 0, 1, 2, 1, -1, 0};
    endfunction

    function void set_margin(logic [MARGIN_WIDTH-1:0] value);
      margin = value;
    endfunction

    function bit drained();
      return predicted_results.size() == 0;
    endfunction

    // advance the state by one accepted sample beat and queue its result
    function void take_sample(in_beat_t beat);
      logic [1:0] quad;
      int         delta;
      longint     cnt;
      longint     cmd;
      longint     err;
      longint     mg;
      out_beat_t  want;
      if (hist_a[0] == beat.chan_a && hist_a[1] == beat.chan_a) filt_a = beat.chan_a;
      if (hist_b[0] == beat.chan_b && hist_b[1] == beat.chan_b) filt_b = beat.chan_b;
      hist_a[0] = hist_a[1];
      hist_a[1] = beat.chan_a;
      hist_b[0] = hist_b[1];
      hist_b[1] = beat.chan_b;
      quad      = {filt_a, filt_b};
      delta     = quad_step[{prev_quad, quad}];
      prev_quad = quad;
      if (beat.clear) count = '0;
      count = count + COUNT_WIDTH'(delta);
      cnt = longint'(count);
      cmd = longint'(beat.commanded_position);
      if (cnt < -FAR_AWAY) begin
        err = SAT_HI;
      end else if (cnt > FAR_AWAY) begin
        err = SAT_LO;
      end else begin
        err = cmd - cnt;
        if (err > SAT_HI) err = SAT_HI;
        if (err < SAT_LO) err = SAT_LO;
      end
      mg = margin;
      want.position       = cnt[31:0];
      want.position_error = err[31:0];
      want.lagging        = err > mg;
      want.leading        = err < -mg;
      want.correction     = (err > 0) ? CORR_FORWARD : ((err < 0) ? CORR_REVERSE : CORR_NONE);
      want.illegal_step   = delta == JUMP_STEP;
      predicted_results.push_back(want);
    endfunction

    function void compare_field(string name, logic signed [31:0] want,
                                logic signed [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    // compare one result beat with the oldest prediction
    function void match_result(out_beat_t got);
      out_beat_t want;
      if (predicted_results.size() == 0) begin
        $error("result beat with no sample pending: position %0d", got.position);
        errors++;
        return;
      end
      want = predicted_results.pop_front();
      compare_field("position", want.position, got.position);
      compare_field("position_error", want.position_error, got.position_error);
      compare_field("lagging", want.lagging, got.lagging);
      compare_field("leading", want.leading, got.leading);
      compare_field("correction", want.correction, got.correction);
      compare_field("illegal_step", want.illegal_step, got.illegal_step);
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  bit   send_idle = 1'b1;
  bit   recv_idle = 1'b1;
  bit   long_hold = 1'b0;
  int   phase_no  = 0;

  position_predictor tracker;

  qpm_stream_if #(.payload_t(in_beat_t))  in_if ();
  qpm_stream_if #(.payload_t(out_beat_t)) out_if ();
  qpm_stream_if #(.payload_t(cfg_beat_t)) cfg_if ();

  filtered_quadrature_position_monitor i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // sample beat, with an optional idle burst ahead of it
  task automatic send_sample(input logic a, input logic b,
                             input logic signed [31:0] cmd, input logic clr);
    in_beat_t beat;
    beat.chan_a             = a;
    beat.chan_b             = b;
    beat.commanded_position = cmd;
    beat.clear              = clr;
    if (send_idle && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= beat;
    do @(posedge clk_i); while (!in_if.ready);
    tracker.take_sample(beat);
  endtask

  // hold one level for n beats, clear on the last one if asked
  task automatic send_run(input logic [1:0] quad, input int n,
                          input logic signed [31:0] cmd, input logic clr_last);
    for (int i = 0; i < n; i++) send_sample(quad[1], quad[0], cmd, clr_last && i == n - 1);
  endtask

  // command near the count or near the margin edges, sometimes anywhere
  function automatic logic signed [31:0] near_cmd();
    logic signed [31:0] base;
    int                 off;
    base = 32'(tracker.count);
    off  = int'(tracker.margin) + $urandom_range(0, 2) - 1;
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return base + $urandom_range(0, 6) - 3;
      default: return $urandom_range(0, 1) ? base + off : base - off;
    endcase
  endfunction

  // encoder motion: gray steps with random holds, jumps, glitches, rare clears
  task automatic run_motion(input int n_items);
    logic [1:0] gray [4];
    logic [1:0] lvl;
    int         pos;
    int         sent;
    int         hold;
    int         k;
    gray = '{2'b00, 2'b10, 2'b11, 2'b01};
    pos  = 0;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(0, 19))
        14, 15: pos = (pos + 2) % 4;
        16, 17, 18: begin
          k = $urandom_range(1, 3);
          repeat (k) begin
            lvl = 2'($urandom);
            send_sample(lvl[1], lvl[0], near_cmd(), 1'b0);
          end
          sent += k;
        end
        default: pos = $urandom_range(0, 1) ? (pos + 1) % 4 : (pos + 3) % 4;
      endcase
      hold = $urandom_range(3, 6);
      repeat (hold) send_sample(gray[pos][1], gray[pos][0], near_cmd(),
                                $urandom_range(0, 39) == 0);
      sent += hold;
    end
  endtask

  // wait until every predicted result has come back
  task automatic settle();
    in_if.valid <= 1'b0;
    while (!tracker.drained()) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_margin(input logic [MARGIN_WIDTH-1:0] value);
    cfg_beat_t beat;
    beat.error_margin = value;
    cfg_if.valid   <= 1'b1;
    cfg_if.payload <= beat;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    tracker.set_margin(value);
  endtask

  // result side: random stall bursts plus one long hold
  initial begin
    int stall_left;
    stall_left    = 0;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) tracker.match_result(out_if.payload);
      if (stall_left > 0) begin
        stall_left--;
      end else if (recv_idle && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 19);
      end
      out_if.ready <= !(long_hold || stall_left > 0);
    end
  end

  // long hold on the result side while samples keep coming
  initial begin
    wait (phase_no == 2);
    repeat (20) @(posedge clk_i);
    long_hold <= 1'b1;
    repeat (150) @(posedge clk_i);
    long_hold <= 1'b0;
  end

  // stimulus
  initial begin
    logic [MARGIN_WIDTH-1:0] margins [5];
    tracker = new();
    in_if.valid    <= 1'b0;
    in_if.payload  <= '0;
    cfg_if.valid   <= 1'b0;
    cfg_if.payload <= '0;
    margins = '{16'd0, 16'hFFFF, 16'd1, 16'($urandom), 16'd7};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: forward steps, illegal jump, reverse, glitch, clear, saturation
    send_run(2'b10, 3, 32'sd0, 1'b0);
    send_run(2'b11, 3, -32'sd1, 1'b0);
    send_run(2'b00, 3, 32'sh8000_0000, 1'b0);
    send_run(2'b01, 3, 32'sh7FFF_FFFF, 1'b0);
    send_sample(1'b1, 1'b1, 32'sd3, 1'b0);
    send_run(2'b01, 1, 32'sd0, 1'b1);
    send_run(2'b11, 3, 32'sh7FFF_FFFF, 1'b0);
    send_run(2'b10, 3, 32'sd5, 1'b1);
    send_sample(1'b1, 1'b0, -32'sd6, 1'b0);
    send_sample(1'b1, 1'b0, -32'sd5, 1'b0);
    settle();

    // random phases over several margins
    for (int p = 1; p <= 5; p++) begin
      write_margin(margins[p-1]);
      send_idle = (p != 2) && (p != 5);
      recv_idle = (p != 5);
      phase_no  = p;
      run_motion(p == 5 ? 300 : 250);
      settle();
    end

    if (tracker.errors == 0) begin
      $display("filtered_quadrature_position_monitor_tb: done, clean");
    end else begin
      $display("filtered_quadrature_position_monitor_tb: done, errors");
    end
    $finish;
  end

  // run limit
  initial begin
    #3_000_000;
    $display("filtered_quadrature_position_monitor_tb: done, errors");
    $finish;
  end

endmodule
